// ----- design/hrrc_pkg.sv -----
// Package for the response report checker: word types, offsets, limits,
// verdict codes and configuration register indexes.
// No dependencies.
package hrrc_pkg;

  // Report geometry
  localparam int unsigned REPORT_BYTES = 90;
  localparam int unsigned MAX_PAYLOAD  = 80;

  localparam logic [7:0] LAST_POS      = 8'(REPORT_BYTES - 1);
  localparam logic [7:0] MAX_PAYLOAD_B = 8'(MAX_PAYLOAD);
  localparam logic [7:0] COUNT_SAT     = 8'd255;

  // Byte offsets inside a report
  localparam logic [7:0] OFS_STATUS   = 8'd0;
  localparam logic [7:0] OFS_TRANS    = 8'd1;
  localparam logic [7:0] OFS_XOR_LO   = 8'd2;
  localparam logic [7:0] OFS_BYTE4    = 8'd4;
  localparam logic [7:0] OFS_SIZE     = 8'd5;
  localparam logic [7:0] OFS_CLASS    = 8'd6;
  localparam logic [7:0] OFS_COMMAND  = 8'd7;
  localparam logic [7:0] OFS_CHECKSUM = 8'd88;

  // Device status codes at offset zero
  localparam logic [7:0] STATUS_BUSY        = 8'd1;
  localparam logic [7:0] STATUS_OK          = 8'd2;
  localparam logic [7:0] STATUS_IO_ERROR    = 8'd3;
  localparam logic [7:0] STATUS_TIMEOUT     = 8'd4;
  localparam logic [7:0] STATUS_UNSUPPORTED = 8'd5;

  // Verdict codes
  localparam logic [2:0] VERDICT_OK          = 3'd0;
  localparam logic [2:0] VERDICT_BUSY        = 3'd1;
  localparam logic [2:0] VERDICT_PROTOCOL    = 3'd2;
  localparam logic [2:0] VERDICT_IO_ERROR    = 3'd3;
  localparam logic [2:0] VERDICT_TIMEOUT     = 3'd4;
  localparam logic [2:0] VERDICT_UNSUPPORTED = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] CFG_IDX_TRANSACTION = 3'd0;
  localparam logic [2:0] CFG_IDX_BYTE_FOUR   = 3'd1;
  localparam logic [2:0] CFG_IDX_CLASS       = 3'd2;
  localparam logic [2:0] CFG_IDX_COMMAND     = 3'd3;
  localparam logic [2:0] CFG_IDX_MIN_PAYLOAD = 3'd4;

  localparam logic [7:0] CLASS_RESET = 8'd13;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0] verdict;
    logic [7:0] payload_size;
  } out_word_t;

endpackage

// ----- design/hid_response_report_checker_unit.sv -----
// Top level of the response report checker: input register, per-report
// state, verdict logic and result register. Uses hrrc_pkg.
// Timing: a byte is registered in the input register at acceptance and folded from there;
// the verdict word is loaded into the result register when the last byte is folded.
// Throughput: one byte per cycle, bounded only by the result register
// draining when a report ends.
// Reset (synchronous, rst_n low): counters and XOR cleared, expected class
// set to 13, other configuration and report-state registers zero, both channels empty.
module hid_response_report_checker_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hrrc_pkg::in_word_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hrrc_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_wdata
);

  // Configuration registers
  logic [7:0] exp_trans_r, exp_byte4_r, exp_class_r, exp_command_r;
  logic [6:0] min_payload_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_trans_r   <= '0;
      exp_byte4_r   <= '0;
      exp_class_r   <= hrrc_pkg::CLASS_RESET;
      exp_command_r <= '0;
      min_payload_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        hrrc_pkg::CFG_IDX_TRANSACTION: exp_trans_r   <= cfg_wdata;
        hrrc_pkg::CFG_IDX_BYTE_FOUR:   exp_byte4_r   <= cfg_wdata;
        hrrc_pkg::CFG_IDX_CLASS:       exp_class_r   <= cfg_wdata;
        hrrc_pkg::CFG_IDX_COMMAND:     exp_command_r <= cfg_wdata;
        hrrc_pkg::CFG_IDX_MIN_PAYLOAD: min_payload_r <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // Input register and handshake
  logic               s1_valid_r;
  hrrc_pkg::in_word_t s1_word_r;
  logic               out_valid_r;
  hrrc_pkg::out_word_t out_word_r;
  logic               out_free;
  logic               s1_go;
  logic               in_accept;

  assign out_free  = !out_valid_r || !out_stall;
  assign s1_go     = s1_valid_r && (!s1_word_r.last_byte || out_free);
  assign in_stall  = s1_valid_r && !s1_go;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_word_r <= in_data;
    end
  end

  // Per-report state
  logic [7:0] byte_count_r, byte_count_nxt;
  logic [7:0] running_xor_r, running_xor_nxt;
  logic [7:0] status_byte_r, status_byte_nxt;
  logic [7:0] size_byte_r, size_byte_nxt;
  logic       mismatch_r, mismatch_nxt;
  logic [2:0] verdict;
  logic [7:0] b;
  logic [7:0] pos;
  logic       length_ok;

  // Fold the registered byte into the report state
  always_comb begin
    b               = s1_word_r.rx_byte;
    pos             = byte_count_r;
    status_byte_nxt = status_byte_r;
    size_byte_nxt   = size_byte_r;
    running_xor_nxt = running_xor_r;
    mismatch_nxt    = mismatch_r;
    case (pos)
      hrrc_pkg::OFS_STATUS:   status_byte_nxt = b;
      hrrc_pkg::OFS_TRANS:    if (b != exp_trans_r) mismatch_nxt = 1'b1;
      hrrc_pkg::OFS_BYTE4:    if (b != exp_byte4_r) mismatch_nxt = 1'b1;
      hrrc_pkg::OFS_SIZE:     size_byte_nxt = b;
      hrrc_pkg::OFS_CLASS:    if (b != exp_class_r) mismatch_nxt = 1'b1;
      hrrc_pkg::OFS_COMMAND:  if (b != exp_command_r) mismatch_nxt = 1'b1;
      hrrc_pkg::OFS_CHECKSUM: if (b != running_xor_r) mismatch_nxt = 1'b1;
      default: ;
    endcase
    if (pos >= hrrc_pkg::OFS_XOR_LO && pos < hrrc_pkg::OFS_CHECKSUM) begin
      running_xor_nxt = running_xor_r ^ b;
    end
    byte_count_nxt = (byte_count_r == hrrc_pkg::COUNT_SAT) ? byte_count_r
                                                           : byte_count_r + 8'd1;
    length_ok = (byte_count_r != hrrc_pkg::COUNT_SAT) && (pos == hrrc_pkg::LAST_POS);
  end

  // Judge the report from the updated state
  always_comb begin
    if ({1'b0, min_payload_r} > hrrc_pkg::MAX_PAYLOAD_B) begin
      verdict = hrrc_pkg::VERDICT_PROTOCOL;
    end else if (!length_ok || size_byte_nxt > hrrc_pkg::MAX_PAYLOAD_B) begin
      verdict = hrrc_pkg::VERDICT_PROTOCOL;
    end else if (mismatch_nxt) begin
      verdict = hrrc_pkg::VERDICT_PROTOCOL;
    end else begin
      case (status_byte_nxt)
        hrrc_pkg::STATUS_BUSY:        verdict = hrrc_pkg::VERDICT_BUSY;
        hrrc_pkg::STATUS_OK:          verdict = (size_byte_nxt < {1'b0, min_payload_r})
                                                ? hrrc_pkg::VERDICT_PROTOCOL
                                                : hrrc_pkg::VERDICT_OK;
        hrrc_pkg::STATUS_IO_ERROR:    verdict = hrrc_pkg::VERDICT_IO_ERROR;
        hrrc_pkg::STATUS_TIMEOUT:     verdict = hrrc_pkg::VERDICT_TIMEOUT;
        hrrc_pkg::STATUS_UNSUPPORTED: verdict = hrrc_pkg::VERDICT_UNSUPPORTED;
        default:                      verdict = hrrc_pkg::VERDICT_PROTOCOL;
      endcase
    end
  end

  // Advance the state; clear it at the end of a report
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r  <= '0;
      running_xor_r <= '0;
      status_byte_r <= '0;
      size_byte_r   <= '0;
      mismatch_r    <= 1'b0;
    end else if (s1_go) begin
      if (s1_word_r.last_byte) begin
        byte_count_r  <= '0;
        running_xor_r <= '0;
        status_byte_r <= '0;
        size_byte_r   <= '0;
        mismatch_r    <= 1'b0;
      end else begin
        byte_count_r  <= byte_count_nxt;
        running_xor_r <= running_xor_nxt;
        status_byte_r <= status_byte_nxt;
        size_byte_r   <= size_byte_nxt;
        mismatch_r    <= mismatch_nxt;
      end
    end
  end

  // Result register: load a verdict word, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_word_r.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_word_r.last_byte) begin
      out_word_r.verdict      <= verdict;
      out_word_r.payload_size <= size_byte_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // Assertions
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_word_r.last_byte |=> byte_count_r == 8'd0 && !mismatch_r)
    else $error("report state not cleared after last byte");

  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && s1_word_r.last_byte && out_valid_r)
    else $error("input stalled without a pending report end");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && !s1_word_r.last_byte && byte_count_r != hrrc_pkg::COUNT_SAT
    |=> byte_count_r == $past(byte_count_r) + 8'd1)
    else $error("byte counter did not advance");

  a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_word_r.verdict <= hrrc_pkg::VERDICT_UNSUPPORTED)
    else $error("verdict code out of range");

endmodule

// ----- tb/sv/hid_response_report_checker_unit_tb.sv -----
// Testbench for hid_response_report_checker_unit: streams response reports one
// byte per word, predicts each verdict word and compares it with the block.
// Depends on hrrc_pkg and the checker RTL only.
module hid_response_report_checker_unit_tb;

  // No register lives at this index; writes to it must be dropped
  localparam logic [2:0] CFG_IDX_SPARE = 3'd7;
  // Cycles to let the last accepted byte settle in the block
  localparam int DRAIN_CYCLES = 6;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  hrrc_pkg::in_word_t  in_data;
  logic                out_valid;
  logic                out_stall;
  hrrc_pkg::out_word_t out_data;
  logic                cfg_we;
  logic [2:0]          cfg_index;
  logic [7:0]          cfg_wdata;

  // Mirror of the configuration registers
  logic [7:0] want_trans;
  logic [7:0] want_byte4;
  logic [7:0] want_class;
  logic [7:0] want_cmd;
  logic [6:0] want_min;

  // Per-report state of the predictor
  logic [7:0] rpt_count;
  logic [7:0] rpt_xor;
  logic [7:0] rpt_status;
  logic [7:0] rpt_size;
  bit         rpt_flagged;

  hrrc_pkg::out_word_t verdict_q[$];
  logic [7:0]          frame[$];
  int                  mismatches;
  int                  hold_req;
  bit                  gaps_on;

  hid_response_report_checker_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Verdict for the report held in the predictor state
  function automatic logic [2:0] judge_report(input bit len_ok);
    if (want_min > hrrc_pkg::MAX_PAYLOAD) return hrrc_pkg::VERDICT_PROTOCOL;
    if (!len_ok || rpt_size > hrrc_pkg::MAX_PAYLOAD_B) return hrrc_pkg::VERDICT_PROTOCOL;
    if (rpt_flagged) return hrrc_pkg::VERDICT_PROTOCOL;
    case (rpt_status)
      hrrc_pkg::STATUS_BUSY:        return hrrc_pkg::VERDICT_BUSY;
      hrrc_pkg::STATUS_OK:          return (rpt_size < {1'b0, want_min})
                                           ? hrrc_pkg::VERDICT_PROTOCOL
                                           : hrrc_pkg::VERDICT_OK;
      hrrc_pkg::STATUS_IO_ERROR:    return hrrc_pkg::VERDICT_IO_ERROR;
      hrrc_pkg::STATUS_TIMEOUT:     return hrrc_pkg::VERDICT_TIMEOUT;
      hrrc_pkg::STATUS_UNSUPPORTED: return hrrc_pkg::VERDICT_UNSUPPORTED;
      default:                      return hrrc_pkg::VERDICT_PROTOCOL;
    endcase
  endfunction

  // Advance the predictor by one accepted word; a last byte yields a verdict
  function automatic void predict_byte(input hrrc_pkg::in_word_t w, output bit has_verdict,
                                       output hrrc_pkg::out_word_t verdict_w);
    logic [7:0] pos;
    bit         len_ok;
    pos = rpt_count;
    has_verdict = 1'b0;
    verdict_w = '0;
    case (pos)
      hrrc_pkg::OFS_STATUS:   rpt_status = w.rx_byte;
      hrrc_pkg::OFS_TRANS:    if (w.rx_byte != want_trans) rpt_flagged = 1'b1;
      hrrc_pkg::OFS_BYTE4:    if (w.rx_byte != want_byte4) rpt_flagged = 1'b1;
      hrrc_pkg::OFS_CLASS:    if (w.rx_byte != want_class) rpt_flagged = 1'b1;
      hrrc_pkg::OFS_COMMAND:  if (w.rx_byte != want_cmd) rpt_flagged = 1'b1;
      hrrc_pkg::OFS_CHECKSUM: if (w.rx_byte != rpt_xor) rpt_flagged = 1'b1;
      default: ;
    endcase
    if (pos == hrrc_pkg::OFS_SIZE) rpt_size = w.rx_byte;
    if (pos >= hrrc_pkg::OFS_XOR_LO && pos < hrrc_pkg::OFS_CHECKSUM) rpt_xor ^= w.rx_byte;
    if (!w.last_byte) begin
      if (rpt_count != hrrc_pkg::COUNT_SAT) rpt_count++;
    end else begin
      len_ok = (rpt_count != hrrc_pkg::COUNT_SAT) && (pos == hrrc_pkg::LAST_POS);
      verdict_w.verdict = judge_report(len_ok);
      verdict_w.payload_size = rpt_size;
      has_verdict = 1'b1;
      rpt_count = '0;
      rpt_xor = '0;
      rpt_status = '0;
      rpt_size = '0;
      rpt_flagged = 1'b0;
    end
  endfunction

  // Offer one word, hold it until accepted, then predict
  task automatic send_word(input logic [7:0] b, input logic last_flag);
    hrrc_pkg::in_word_t  w;
    bit                  got;
    hrrc_pkg::out_word_t v;
    w.rx_byte = b;
    w.last_byte = last_flag;
    if (gaps_on && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_byte(w, got, v);
    if (got) verdict_q.push_back(v);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame.size(); i++) send_word(frame[i], i == frame.size() - 1);
  endtask

  // Well-formed report for the current configuration, random filler
  function automatic void build_frame(input logic [7:0] status, input logic [7:0] size);
    logic [7:0] sum;
    sum = 8'h00;
    frame.delete();
    for (int i = 0; i < hrrc_pkg::REPORT_BYTES; i++) frame.push_back(8'($urandom));
    frame[hrrc_pkg::OFS_STATUS] = status;
    frame[hrrc_pkg::OFS_TRANS] = want_trans;
    frame[hrrc_pkg::OFS_BYTE4] = want_byte4;
    frame[hrrc_pkg::OFS_SIZE] = size;
    frame[hrrc_pkg::OFS_CLASS] = want_class;
    frame[hrrc_pkg::OFS_COMMAND] = want_cmd;
    for (int i = hrrc_pkg::OFS_XOR_LO; i < hrrc_pkg::OFS_CHECKSUM; i++) sum ^= frame[i];
    frame[hrrc_pkg::OFS_CHECKSUM] = sum;
  endfunction

  function automatic void resize_frame(input int n);
    while (frame.size() > n) void'(frame.pop_back());
    while (frame.size() < n) frame.push_back(8'($urandom));
  endfunction

  task automatic send_report(input logic [7:0] status, input logic [7:0] size);
    build_frame(status, size);
    send_frame();
  endtask

  // Drop valid and wait until every verdict has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      hrrc_pkg::CFG_IDX_TRANSACTION: want_trans = val;
      hrrc_pkg::CFG_IDX_BYTE_FOUR:   want_byte4 = val;
      hrrc_pkg::CFG_IDX_CLASS:       want_class = val;
      hrrc_pkg::CFG_IDX_COMMAND:     want_cmd = val;
      hrrc_pkg::CFG_IDX_MIN_PAYLOAD: want_min = val[6:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] t, input logic [7:0] b4, input logic [7:0] c,
                            input logic [7:0] cmd, input logic [7:0] mn);
    write_reg(hrrc_pkg::CFG_IDX_TRANSACTION, t);
    write_reg(hrrc_pkg::CFG_IDX_BYTE_FOUR, b4);
    write_reg(hrrc_pkg::CFG_IDX_CLASS, c);
    write_reg(hrrc_pkg::CFG_IDX_COMMAND, cmd);
    write_reg(hrrc_pkg::CFG_IDX_MIN_PAYLOAD, mn);
  endtask

  // Result side: check each accepted word, then drive stall
  initial begin : result_sink
    int                  hold_left;
    hrrc_pkg::out_word_t want;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("verdict word %0d/%0d with nothing pending",
                                    out_data.verdict, out_data.payload_size));
        end else begin
          want = verdict_q.pop_front();
          if (out_data.verdict !== want.verdict)
            report_mismatch($sformatf("verdict %0d, predicted %0d",
                                      out_data.verdict, want.verdict));
          if (out_data.payload_size !== want.payload_size)
            report_mismatch($sformatf("payload_size %0d, predicted %0d",
                                      out_data.payload_size, want.payload_size));
        end
      end
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= gaps_on && ($urandom_range(99) < 16);
      end
    end
  end

  // Reset values: class 13 expected, minimum payload zero
  task automatic test_reset_config();
    send_report(hrrc_pkg::STATUS_OK, 8'd0);
  endtask

  // Every other status code plus a value with no meaning, with no idling
  task automatic test_status_codes();
    gaps_on = 1'b0;
    send_report(hrrc_pkg::STATUS_BUSY, 8'd3);
    send_report(hrrc_pkg::STATUS_IO_ERROR, 8'd3);
    send_report(hrrc_pkg::STATUS_TIMEOUT, 8'd3);
    send_report(hrrc_pkg::STATUS_UNSUPPORTED, 8'd3);
    send_report(8'd6, 8'd3);
    gaps_on = 1'b1;
  endtask

  // Break one compared offset, a checksum input, or an ignored byte
  task automatic test_checked_offsets();
    logic [7:0] spots[7];
    logic [7:0] spot;
    spots = '{hrrc_pkg::OFS_TRANS, hrrc_pkg::OFS_BYTE4, hrrc_pkg::OFS_CLASS,
              hrrc_pkg::OFS_COMMAND, hrrc_pkg::OFS_CHECKSUM, hrrc_pkg::OFS_XOR_LO,
              hrrc_pkg::LAST_POS};
    spot = spots[$urandom_range(6)];
    build_frame(hrrc_pkg::STATUS_OK, 8'd10);
    frame[spot] ^= 8'($urandom_range(1, 255));
    send_frame();
  endtask

  // Size byte against the configured minimum and the maximum
  task automatic test_size_limits();
    write_reg(hrrc_pkg::CFG_IDX_MIN_PAYLOAD, 8'd40);
    send_report(hrrc_pkg::STATUS_OK, 8'd39);
    send_report(hrrc_pkg::STATUS_BUSY, hrrc_pkg::MAX_PAYLOAD_B + 8'd1);
  endtask

  // Short and long reports
  task automatic test_length();
    int lens[2];
    lens = '{5, 91};
    foreach (lens[i]) begin
      build_frame(hrrc_pkg::STATUS_OK, 8'd12);
      resize_frame(lens[i]);
      send_frame();
    end
  endtask

  // Minimum above maximum through a masked write, spare index, then rewrite every register
  task automatic test_config_extremes();
    // bit 7 of the write data falls outside the 7-bit minimum
    write_reg(hrrc_pkg::CFG_IDX_MIN_PAYLOAD, 8'hD1);
    send_report(hrrc_pkg::STATUS_OK, hrrc_pkg::MAX_PAYLOAD_B);
    write_reg(CFG_IDX_SPARE, 8'hFF);
    set_config(8'h5A, 8'hA5, hrrc_pkg::CLASS_RESET, 8'h3C, 8'd0);
  endtask

  // Receiver holds off while short reports keep coming, then a full pause
  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_req = 300;
    for (int i = 0; i < 40; i++) begin
      frame.delete();
      frame.push_back(8'($urandom));
      send_frame();
    end
    wait_idle();
    gaps_on = 1'b1;
  endtask

  initial begin : run_tests
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    gaps_on = 1'b0;
    hold_req = 0;
    mismatches = 0;
    want_trans = 8'h00;
    want_byte4 = 8'h00;
    want_class = hrrc_pkg::CLASS_RESET;
    want_cmd = 8'h00;
    want_min = 7'd0;
    rpt_count = '0;
    rpt_xor = '0;
    rpt_status = '0;
    rpt_size = '0;
    rpt_flagged = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gaps_on = 1'b1;
    test_reset_config();
    test_status_codes();
    test_checked_offsets();
    test_size_limits();
    test_length();
    test_config_extremes();
    test_backpressure();
    wait_idle();
    if (mismatches == 0) begin
      $display("hid_response_report_checker_unit_tb passed");
    end else begin
      $display("hid_response_report_checker_unit_tb failed");
    end
    $finish;
  end

  // Hard stop for a hung handshake
  initial begin : run_limit
    #2000000;
    $display("hid_response_report_checker_unit_tb failed");
    $finish;
  end

endmodule
